>>> design/matrix_multiply_row_stream_macros.svh
// assertion macros for the row-streaming matrix product
`ifndef MATRIX_MULTIPLY_ROW_STREAM_MACROS_SVH
`define MATRIX_MULTIPLY_ROW_STREAM_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, disabled during reset
`define MMRS_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, disabled during reset
`define MMRS_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define MMRS_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons)
`define MMRS_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons)

`endif

`endif

>>> design/mmrs_pkg.sv
package mmrs_pkg;

  localparam int DEF_MAX_INNER = 64;
  localparam int DEF_MAX_COLS  = 64;

  localparam int VALUE_W    = 32;
  localparam int SUM_W      = 64;
  localparam int COL_IDX_W  = 6;
  localparam int ROW_IDX_W  = 6;
  localparam int ROWCNT_W   = 16;
  localparam int SIZE_W     = 7;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_INNER_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_COLS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 2'd2;

  localparam logic [SIZE_W-1:0]   RST_INNER_SIZE  = 7'd64;
  localparam logic [SIZE_W-1:0]   RST_OUT_COLS    = 7'd64;
  localparam logic [ROWCNT_W-1:0] RST_ROWS_IN_USE = 16'd1;

  localparam logic [SUM_W-1:0] SUM_POS_LIMIT = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SUM_NEG_LIMIT = {1'b1, {(SUM_W-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_DRAIN,
    ST_EMIT_RD,
    ST_EMIT_LD
  } mmrs_state_t;

  // tag travelling with a read issued to the multiply-accumulate pipeline
  typedef struct packed {
    logic                 valid;
    logic [COL_IDX_W-1:0] col;
  } mac_tag_t;

  // write-back of one accumulator
  typedef struct packed {
    logic                 en;
    logic [COL_IDX_W-1:0] col;
    logic [SUM_W-1:0]     data;
  } acc_wr_t;

endpackage

>>> design/matrix_multiply_row_stream.sv
// row-streaming dense matrix product C = A x B in Q16.16, sums in Q32.32 with
// saturation. load words (kind 0) write one element of B into the B memory.
// an A word (kind 1) drives one shared multiply-accumulate that walks the row
// of accumulators in the sum memory, one column a cycle, then the pipeline
// drains before the next word is accepted. on the last A word of a row the
// out_cols results follow in column order, each read from the sum memory and
// then loaded into the output register, the read waiting while that register
// is full. the sum memory has one read and one write port. the block takes
// new words while the final result of a row still waits in the output register.
`include "matrix_multiply_row_stream_macros.svh"

module matrix_multiply_row_stream #(
  parameter int MAX_INNER = mmrs_pkg::DEF_MAX_INNER,
  parameter int MAX_COLS  = mmrs_pkg::DEF_MAX_COLS
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration write port
  input  logic                              cfg_we,
  input  logic [mmrs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mmrs_pkg::CFG_DATA_W-1:0]   cfg_data,
  // input words
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              kind,
  input  logic [mmrs_pkg::ROW_IDX_W-1:0]    b_row,
  input  logic [mmrs_pkg::COL_IDX_W-1:0]    b_col,
  input  logic signed [mmrs_pkg::VALUE_W-1:0] value,
  // result words
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [mmrs_pkg::ROWCNT_W-1:0]     out_row,
  output logic [mmrs_pkg::COL_IDX_W-1:0]    out_col,
  output logic signed [mmrs_pkg::SUM_W-1:0] c_value,
  output logic                              last_of_row,
  output logic                              last_of_matrix
);
  import mmrs_pkg::*;

  // only the first 64 rows of B can be addressed
  localparam int ROWS = (MAX_INNER < 64) ? MAX_INNER : 64;
  localparam int BDEPTH = ROWS * MAX_COLS;
  localparam int BAW = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;
  localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  // configuration registers
  logic [SIZE_W-1:0]   inner_size;
  logic [SIZE_W-1:0]   out_cols;
  logic [ROWCNT_W-1:0] rows_in_use;

  // row state
  logic [ROW_IDX_W-1:0] a_position;
  logic [ROW_IDX_W-1:0] row_pos;
  logic [ROWCNT_W-1:0]  row_counter;
  logic                 row_end;
  logic                 b_zero;
  logic signed [VALUE_W-1:0] a_val;

  // column walk, one wider than the index so it can hold the count
  logic [SIZE_W-1:0] col;

  mmrs_state_t state, state_next;

  // effective sizes after clamping
  logic [SIZE_W-1:0]   n_eff;
  logic [SIZE_W-1:0]   k_eff;
  logic [ROWCNT_W-1:0] rows_eff;
  logic                last_row;
  logic                col_last;
  logic                out_free;
  logic                rd_issue;
  logic                in_take;

  // memories and the multiply-accumulate unit
  logic             b_we;
  logic [BAW-1:0]   b_waddr;
  logic [BAW-1:0]   b_raddr;
  logic [VALUE_W-1:0] b_rdata;
  logic [SUM_W-1:0] sum_rdata;
  logic             sum_vld [MAX_COLS];
  logic             rd_vld;
  logic [SUM_W-1:0] sum_masked;
  mac_tag_t         tag;
  acc_wr_t          acc_wr;
  logic             mac_busy;

  always_comb begin
    if (inner_size == '0) begin
      n_eff = SIZE_W'(1);
    end else if (inner_size > SIZE_W'(ROWS)) begin
      n_eff = SIZE_W'(ROWS);
    end else begin
      n_eff = inner_size;
    end
    if (out_cols == '0) begin
      k_eff = SIZE_W'(1);
    end else if (out_cols > SIZE_W'(MAX_COLS)) begin
      k_eff = SIZE_W'(MAX_COLS);
    end else begin
      k_eff = out_cols;
    end
    rows_eff = (rows_in_use == '0) ? ROWCNT_W'(1) : rows_in_use;
  end

  // a row past the configured count still closes the matrix
  assign last_row = ({1'b0, row_counter} + (ROWCNT_W+1)'(1)) >= {1'b0, rows_eff};
  assign col_last = (col == k_eff - SIZE_W'(1));
  assign out_free = !out_valid || out_ready;
  assign in_take  = in_valid && in_ready;

  // configuration writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      inner_size  <= RST_INNER_SIZE;
      out_cols    <= RST_OUT_COLS;
      rows_in_use <= RST_ROWS_IN_USE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INNER_SIZE:  inner_size  <= cfg_data[SIZE_W-1:0];
        REG_OUT_COLS:    out_cols    <= cfg_data[SIZE_W-1:0];
        REG_ROWS_IN_USE: rows_in_use <= cfg_data[ROWCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_take && kind) begin
          state_next = ST_ACC;
        end
      end
      ST_ACC: begin
        if (col_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!mac_busy) begin
          state_next = row_end ? ST_EMIT_RD : ST_IDLE;
        end
      end
      ST_EMIT_RD: begin
        if (out_free) begin
          state_next = ST_EMIT_LD;
        end
      end
      ST_EMIT_LD: begin
        state_next = col_last ? ST_IDLE : ST_EMIT_RD;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready  = 1'b0;
    rd_issue  = 1'b0;
    tag.valid = 1'b0;
    tag.col   = COL_IDX_W'(col);
    unique case (state)
      ST_IDLE:    in_ready = 1'b1;
      ST_ACC: begin
        rd_issue  = 1'b1;
        tag.valid = 1'b1;
      end
      ST_EMIT_RD: rd_issue = out_free;
      ST_DRAIN, ST_EMIT_LD: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // row and column bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      a_position  <= '0;
      row_counter <= '0;
      col         <= '0;
      row_end     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (in_take && kind) begin
        // an element at or past the last position closes the row
        if (({1'b0, a_position} + SIZE_W'(1)) < n_eff) begin
          row_end    <= 1'b0;
          a_position <= a_position + ROW_IDX_W'(1);
        end else begin
          row_end    <= 1'b1;
          a_position <= '0;
        end
      end
      if (state == ST_ACC) begin
        col <= col_last ? '0 : col + SIZE_W'(1);
      end
      if (state == ST_EMIT_LD) begin
        out_valid <= 1'b1;
        if (col_last) begin
          col         <= '0;
          row_counter <= last_row ? '0 : row_counter + ROWCNT_W'(1);
        end else begin
          col <= col + SIZE_W'(1);
        end
      end
    end
  end

  // A element latched for the whole column walk
  always_ff @(posedge clk) begin
    if (in_take && kind) begin
      a_val  <= value;
      b_zero <= ({1'b0, a_position} >= SIZE_W'(ROWS));
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (state == ST_EMIT_LD) begin
      out_row        <= row_counter;
      out_col        <= COL_IDX_W'(col);
      c_value        <= $signed(sum_masked);
      last_of_row    <= col_last;
      last_of_matrix <= col_last && last_row;
    end
  end

  // B memory, written by load words, read along the current row
  assign b_we    = in_take && !kind && ({1'b0, b_row} < SIZE_W'(ROWS))
                   && ({1'b0, b_col} < SIZE_W'(MAX_COLS));
  assign b_waddr = BAW'(32'(b_row) * 32'(MAX_COLS) + 32'(b_col));
  assign b_raddr = BAW'(32'(row_pos) * 32'(MAX_COLS) + 32'(col));

  // row of B in use: the position register has already moved on at acceptance
  always_ff @(posedge clk) begin
    if (in_take && kind) begin
      row_pos <= a_position;
    end
  end

  mmrs_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (BDEPTH)
  ) u_b_mem (
    .clk     (clk),
    .wr_en   (b_we),
    .wr_addr (b_waddr),
    .wr_data (value),
    .rd_en   (rd_issue),
    .rd_addr (b_raddr),
    .rd_data (b_rdata)
  );

  // accumulator memory, an entry without its valid bit reads as zero
  mmrs_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_COLS)
  ) u_sum_mem (
    .clk     (clk),
    .wr_en   (acc_wr.en),
    .wr_addr (acc_wr.col[CW-1:0]),
    .wr_data (acc_wr.data),
    .rd_en   (rd_issue),
    .rd_addr (col[CW-1:0]),
    .rd_data (sum_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_COLS; i++) begin
        sum_vld[i] <= 1'b0;
      end
      rd_vld <= 1'b0;
    end else begin
      if (rd_issue) begin
        rd_vld <= sum_vld[col[CW-1:0]];
      end
      if (acc_wr.en) begin
        sum_vld[acc_wr.col[CW-1:0]] <= 1'b1;
      end
      // row done: every accumulator back to zero
      if (state == ST_EMIT_LD && col_last) begin
        for (int i = 0; i < MAX_COLS; i++) begin
          sum_vld[i] <= 1'b0;
        end
      end
    end
  end

  assign sum_masked = rd_vld ? sum_rdata : '0;

  mmrs_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .tag    (tag),
    .a_val  (a_val),
    .b_data (b_rdata),
    .b_zero (b_zero),
    .sum_in (sum_masked),
    .wr     (acc_wr),
    .busy   (mac_busy)
  );

  // a new word never meets an accumulation still in flight
  `MMRS_ASSERT_NOW(a_ready_idle_mac, clk, rst, in_ready, !mac_busy)
  // write-backs only while the column walk or its drain runs
  `MMRS_ASSERT_NOW(a_wr_in_acc, clk, rst, acc_wr.en, (state == ST_ACC || state == ST_DRAIN))
  // a result is loaded only into an empty output register
  `MMRS_ASSERT_NOW(a_load_empty, clk, rst, state == ST_EMIT_LD, !out_valid)
  // every loaded result sets the output word valid next cycle
  `MMRS_ASSERT_NEXT(a_load_valid, clk, rst, state == ST_EMIT_LD, out_valid)

endmodule

>>> design/mmrs_ram.sv
module mmrs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> design/mmrs_mac.sv
module mmrs_mac (
  input  logic                            clk,
  input  logic                            rst,
  input  mmrs_pkg::mac_tag_t              tag,
  input  logic signed [mmrs_pkg::VALUE_W-1:0] a_val,
  input  logic [mmrs_pkg::VALUE_W-1:0]    b_data,
  input  logic                            b_zero,
  input  logic [mmrs_pkg::SUM_W-1:0]      sum_in,
  output mmrs_pkg::acc_wr_t               wr,
  output logic                            busy
);
  import mmrs_pkg::*;

  mac_tag_t                s1_tag;
  mac_tag_t                s2_tag;
  logic signed [SUM_W-1:0] s2_prod;
  logic [SUM_W-1:0]        s2_sum;
  logic [SUM_W:0]          full;
  logic signed [VALUE_W-1:0] b_eff;

  assign b_eff = b_zero ? '0 : $signed(b_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_tag.valid <= 1'b0;
      s2_tag.valid <= 1'b0;
    end else begin
      s1_tag.valid <= tag.valid;
      s2_tag.valid <= s1_tag.valid;
    end
    s1_tag.col <= tag.col;
    s2_tag.col <= s1_tag.col;
    s2_prod    <= a_val * b_eff;
    s2_sum     <= sum_in;
  end

  // saturating add, clamp on sign overflow
  always_comb begin
    full = {s2_sum[SUM_W-1], s2_sum} + {s2_prod[SUM_W-1], s2_prod};
    wr.en  = s2_tag.valid;
    wr.col = s2_tag.col;
    if (full[SUM_W] != full[SUM_W-1]) begin
      wr.data = full[SUM_W] ? SUM_NEG_LIMIT : SUM_POS_LIMIT;
    end else begin
      wr.data = full[SUM_W-1:0];
    end
  end

  assign busy = s1_tag.valid | s2_tag.valid;

endmodule
